// ===== rtl/vit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vit_pkg;
    localparam int unsigned MAX_AGENTS_DEF  = 8;
    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned VALUE_BITS_DEF  = 16;
    localparam int unsigned SLOT_BITS       = 10;
    localparam int unsigned ELEM_BITS       = 17;
    localparam int unsigned CNT_BITS        = 4;
    localparam int unsigned OWN_BITS        = 3;
    localparam int unsigned IDX_BITS        = 1;

    localparam logic [IDX_BITS-1:0] REG_AGENT_COUNT = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_OWN_AGENT   = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DECIDE,
        S_WRITE,
        S_READ,
        S_EMIT
    } t_state;

    // compare cell control, shared by every cell of the row
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== rtl/vit_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface vit_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [15:0] element_in;
    logic [9:0] query_slot;
    modport source (output valid, mode, element_in, query_slot, input ready);
    modport sink   (input valid, mode, element_in, query_slot, output ready);
endinterface

interface vit_out_if;
    logic              valid;
    logic              ready;
    logic [9:0]        slot_out;
    logic signed [16:0] element_out;
    logic              last;
    logic [1:0]        status;
    modport source (output valid, slot_out, element_out, last, status, input ready);
    modport sink   (input valid, slot_out, element_out, last, status, output ready);
endinterface

interface vit_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/vit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One word of the compare chain: holds one gathered word, takes a word from
// the memory stream, and passes its own stored word to the next cell.
module vit_cell
    import vit_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire [VALUE_BITS-1:0]  i_load_word,
    input  wire [VALUE_BITS-1:0]  i_prev_word,
    input  wire [VALUE_BITS-1:0]  i_mem_word,
    input  wire                   i_used,
    output logic [VALUE_BITS-1:0] o_word,
    output logic                  o_eq
);
    logic [VALUE_BITS-1:0] r_word;

    // gather load or shift along the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_load_word;
        end else if (i_ctl.shift) begin
            r_word <= i_prev_word;
        end
    end

    assign o_word = r_word;
    assign o_eq   = !i_used || (r_word == i_mem_word);
endmodule
`default_nettype wire

// ===== rtl/vector_interning_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Insert beat that does not complete a vector: taken in S_IDLE, no result.
// Completing insert: linear scan, each stored slot read in S_SCAN and compared
// in S_WAIT; a hit ends the scan, a new or full entry is decided once all N
// stored slots are compared (N up to TABLE_DEPTH); the result leaves from S_DECIDE.
// Read: a stored slot goes through S_READ to S_EMIT, then one beat per agent per
// cycle while the output is not stalled; an unstored slot gives its single result from S_EMIT.
// Sync active-low reset clears state, fill count, position, own agent and output valid
// and sets agent count to 2; entry memory is not cleared (fill count marks stored slots).
module vector_interning_table
    import vit_pkg::*;
#(
    parameter int unsigned MAX_AGENTS  = MAX_AGENTS_DEF,
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    vit_in_if.sink   in_ch,
    vit_out_if.source out_ch,
    vit_cfg_if.sink  cfg_ch
);
    localparam int unsigned WORDS = MAX_AGENTS - 1;
    localparam int unsigned WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned AB    = $clog2(MAX_AGENTS + 1);
    localparam int unsigned TB    = $clog2(TABLE_DEPTH);
    localparam int unsigned EB    = TB + 1;
    localparam int unsigned ROWW  = WORDS * VALUE_BITS;

    t_state r_state, n_state;
    logic [CNT_BITS-1:0] r_agent_count;
    logic [OWN_BITS-1:0] r_own_agent;
    logic [EB-1:0]       r_count;
    logic [AB-1:0]       r_pos;
    logic [EB-1:0]       r_idx;
    logic                r_found;
    logic [TB-1:0]       r_hit;
    logic [SLOT_BITS-1:0] r_slot;
    logic [AB-1:0]       r_emit;
    logic [WB-1:0]       w_word_i;
    logic [ROWW-1:0]     r_rdata;
    logic [ROWW-1:0]     r_mem [TABLE_DEPTH];

    // output register
    logic                r_ovalid;
    logic [SLOT_BITS-1:0] r_oslot;
    logic [ELEM_BITS-1:0] r_oelem;
    logic                r_olast;
    logic [1:0]          r_ostat;

    // effective agent count and own position
    logic [AB-1:0] w_cnt, w_own;
    always_comb begin
        if (r_agent_count < CNT_BITS'(2)) w_cnt = AB'(2);
        else if (32'(r_agent_count) > MAX_AGENTS) w_cnt = AB'(MAX_AGENTS);
        else w_cnt = AB'(r_agent_count);
        w_own = (AB'(r_own_agent) < w_cnt) ? AB'(r_own_agent) : w_cnt - AB'(1);
    end

    wire w_in_acc  = in_ch.valid && in_ch.ready;
    wire w_cfg_acc = cfg_ch.valid && cfg_ch.ready;
    wire w_out_free = !r_ovalid || out_ch.ready;
    wire w_load_out = w_out_free && (r_state == S_DECIDE || r_state == S_EMIT);
    assign in_ch.ready  = (r_state == S_IDLE) && !cfg_ch.valid;
    assign cfg_ch.ready = (r_state == S_IDLE);

    // gather row of cells; an element enters cell 0 and shifts toward the end
    wire w_keep = w_in_acc && in_ch.mode == MODE_INSERT && r_pos != w_own;
    t_cell_ctl w_ctl;
    assign w_ctl.load  = 1'b0;
    assign w_ctl.shift = w_keep;
    logic [VALUE_BITS-1:0] w_word [WORDS];
    logic [VALUE_BITS-1:0] w_mem_word [WORDS];
    logic [WORDS-1:0]      w_eq;
    logic [AB-1:0]         w_words;
    assign w_words = w_cnt - AB'(1);

    // row words lined up with the cells: cell g holds word (words-1-g)
    always_comb begin
        for (int k = 0; k < WORDS; k++) begin
            w_mem_word[k] = '0;
            if (AB'(k) < w_words)
                w_mem_word[k] = r_rdata[(int'(w_words) - 1 - k)*VALUE_BITS +: VALUE_BITS];
        end
    end

    genvar g;
    generate
        for (g = 0; g < WORDS; g++) begin : g_cell
            // after k shifts, word j of the vector sits in cell (k-1-j);
            // a row is compared with cell index mapped back to word index
            vit_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_load_word(in_ch.element_in[VALUE_BITS-1:0]),
                .i_prev_word((g == 0) ? in_ch.element_in[VALUE_BITS-1:0]
                                      : w_word[(g == 0) ? 0 : g - 1]),
                .i_mem_word (w_mem_word[g]),
                .i_used     (AB'(g) < w_words),
                .o_word     (w_word[g]),
                .o_eq       (w_eq[g])
            );
        end
    endgenerate

    // memory row holds the vector words in order, word 0 lowest
    logic [ROWW-1:0] w_row;
    always_comb begin
        w_row = '0;
        for (int k = 0; k < WORDS; k++) begin
            if (AB'(k) < w_words)
                w_row[k*VALUE_BITS +: VALUE_BITS] = w_word[int'(w_words) - 1 - k];
        end
    end

    wire w_last_el = (r_pos + AB'(1)) >= w_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (in_ch.mode == MODE_READ) begin
                        n_state = (EB'(in_ch.query_slot) < r_count &&
                                   32'(in_ch.query_slot) < TABLE_DEPTH)
                                  ? S_READ : S_EMIT;
                    end else if (w_last_el) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN:   n_state = (r_idx < r_count) ? S_WAIT : S_DECIDE;
            S_WAIT:   n_state = (&w_eq) ? S_DECIDE : S_SCAN;
            S_DECIDE: if (w_out_free) n_state = S_IDLE;
            S_READ:   n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free && (!r_found || r_emit + AB'(1) >= w_cnt))
                    n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_agent_count <= CNT_BITS'(2);
            r_own_agent   <= '0;
            r_count       <= '0;
            r_pos         <= '0;
            r_ovalid      <= 1'b0;
            r_found       <= 1'b0;
            r_idx         <= '0;
            r_emit        <= '0;
        end else begin
            if (w_load_out) r_ovalid <= 1'b1;
            else if (out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_found <= 1'b0;
                    r_idx   <= '0;
                    r_emit  <= '0;
                    if (w_cfg_acc) begin
                        r_pos <= '0;
                        if (cfg_ch.index == REG_AGENT_COUNT) r_agent_count <= cfg_ch.data;
                        else r_own_agent <= cfg_ch.data[OWN_BITS-1:0];
                    end else if (w_in_acc) begin
                        r_slot <= in_ch.query_slot;
                        if (in_ch.mode == MODE_READ) r_pos <= '0;
                        else r_pos <= w_last_el ? AB'(0) : r_pos + AB'(1);
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_count) r_rdata <= r_mem[r_idx[TB-1:0]];
                end
                S_WAIT: begin
                    if (&w_eq) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx[TB-1:0];
                    end
                    r_idx <= r_idx + EB'(1);
                end
                S_READ: begin
                    r_rdata <= r_mem[r_slot[TB-1:0]];
                    r_found <= 1'b1;
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        r_olast  <= 1'b1;
                        r_oelem  <= '0;
                        if (r_found) begin
                            r_oslot <= SLOT_BITS'(r_hit);
                            r_ostat <= ST_OK;
                        end else if (32'(r_count) >= TABLE_DEPTH) begin
                            r_oslot <= '0;
                            r_ostat <= ST_FULL;
                        end else begin
                            r_oslot <= SLOT_BITS'(r_count);
                            r_ostat <= ST_OK;
                            r_mem[r_count[TB-1:0]] <= w_row;
                            r_count <= r_count + EB'(1);
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_oslot  <= r_slot;
                        if (!r_found) begin
                            r_oelem <= '0;
                            r_olast <= 1'b1;
                            r_ostat <= ST_MISS;
                        end else begin
                            r_ostat <= ST_OK;
                            r_olast <= (r_emit + AB'(1) >= w_cnt);
                            if (r_emit == w_own) begin
                                r_oelem <= '1;
                            end else begin
                                r_oelem <= ELEM_BITS'(r_rdata[w_word_i*VALUE_BITS +: VALUE_BITS]);
                            end
                        end
                        r_emit <= r_emit + AB'(1);
                    end
                end
                default: ;
            endcase
            r_state <= n_state;
        end
    end

    // row word for the current read beat, skipping the own position
    always_comb begin
        logic [AB-1:0] j;
        j = (r_emit < w_own) ? r_emit : r_emit - AB'(1);
        w_word_i = WB'(j);
    end

    assign out_ch.valid       = r_ovalid;
    assign out_ch.slot_out    = r_oslot;
    assign out_ch.element_out = r_oelem;
    assign out_ch.last        = r_olast;
    assign out_ch.status      = r_ostat;

    // fill count never passes the depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= TABLE_DEPTH) else $error("entry count overflow");
    // a full-table status is only given when the table is full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ostat == ST_FULL |-> 32'(r_count) >= TABLE_DEPTH)
        else $error("full flagged early");
    // no input is taken while an item is in work
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !in_ch.ready) else $error("input taken while busy");
endmodule
`default_nettype wire

// ===== verif/vector_interning_table_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vector_interning_table_tb;
    import vit_pkg::*;

    localparam int unsigned VEC_AGENTS  = MAX_AGENTS_DEF;
    localparam int unsigned NUM_SLOTS   = TABLE_DEPTH_DEF;
    localparam int unsigned SLOT_WORDS  = MAX_AGENTS_DEF - 1;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE      = 16;

    typedef logic [VEC_AGENTS-1:0][15:0] t_agent_vec;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [ELEM_BITS-1:0] elem;
        logic                 last;
        logic [1:0]           status;
    } t_result_beat;

    // Tracks the interned table and the results it must produce
    class intern_scoreboard;
        logic [15:0]      entries [NUM_SLOTS][SLOT_WORDS];
        logic [15:0]      gather [SLOT_WORDS];
        int unsigned      n_entries;
        int unsigned      position;
        logic [3:0]       agent_reg;
        logic [2:0]       own_reg;
        t_result_beat     pending [$];
        int unsigned      n_errors;

        function new();
            n_entries = 0;
            position  = 0;
            agent_reg = 4'd2;
            own_reg   = 3'd0;
            n_errors  = 0;
        endfunction

        function int unsigned agents();
            if (agent_reg < 2) return 2;
            if (agent_reg > VEC_AGENTS) return VEC_AGENTS;
            return agent_reg;
        endfunction

        function int unsigned own_pos();
            int unsigned cnt;
            cnt = agents();
            return (own_reg < cnt) ? own_reg : cnt - 1;
        endfunction

        function void note_reg(logic [IDX_BITS-1:0] idx, logic [3:0] data);
            if (idx == REG_AGENT_COUNT) agent_reg = data;
            else if (idx == REG_OWN_AGENT) own_reg = data[2:0];
            position = 0;
        endfunction

        function void push(logic [SLOT_BITS-1:0] slot, logic [ELEM_BITS-1:0] elem,
                           logic last, logic [1:0] status);
            t_result_beat r;
            r.slot = slot; r.elem = elem; r.last = last; r.status = status;
            pending.push_back(r);
        endfunction

        function void note_beat(logic mode, logic [15:0] elem, logic [9:0] qslot);
            int unsigned cnt, own, words, j;
            bit same;
            cnt   = agents();
            own   = own_pos();
            words = cnt - 1;
            if (mode == MODE_INSERT) begin
                if (position != own) begin
                    j = (position < own) ? position : position - 1;
                    gather[j] = elem;
                end
                if (position + 1 < cnt) begin
                    position++;
                    return;
                end
                position = 0;
                // search stored entries in slot order
                for (int i = 0; i < n_entries; i++) begin
                    same = 1;
                    for (int w = 0; w < words; w++)
                        if (entries[i][w] != gather[w]) same = 0;
                    if (same) begin
                        push(SLOT_BITS'(i), '0, 1'b1, ST_OK);
                        return;
                    end
                end
                if (n_entries >= NUM_SLOTS) begin
                    push('0, '0, 1'b1, ST_FULL);
                    return;
                end
                for (int w = 0; w < words; w++) entries[n_entries][w] = gather[w];
                push(SLOT_BITS'(n_entries), '0, 1'b1, ST_OK);
                n_entries++;
            end else begin
                position = 0;
                if (qslot >= n_entries) begin
                    push(qslot, '0, 1'b1, ST_MISS);
                    return;
                end
                j = 0;
                for (int i = 0; i < cnt; i++) begin
                    if (i == own) begin
                        push(qslot, '1, i == cnt - 1, ST_OK);
                    end else begin
                        push(qslot, {1'b0, entries[qslot][j]}, i == cnt - 1, ST_OK);
                        j++;
                    end
                end
            end
        endfunction

        function void check(t_result_beat got);
            t_result_beat exp_r;
            if (pending.size() == 0) begin
                $error("result beat with no expectation: slot %0d", got.slot);
                n_errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.slot !== exp_r.slot) begin
                $error("slot_out: expected %0d, got %0d", exp_r.slot, got.slot);
                n_errors++;
            end
            if (got.elem !== exp_r.elem) begin
                $error("element_out: expected %h, got %h", exp_r.elem, got.elem);
                n_errors++;
            end
            if (got.last !== exp_r.last) begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                n_errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   out_stall = 0;
    int   quiet_cycles = 0;

    intern_scoreboard sb;
    t_agent_vec       vec_pool [$];

    vit_in_if  in_ch ();
    vit_out_if out_ch ();
    vit_cfg_if cfg_ch ();

    vector_interning_table i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result beats are checked on acceptance
    always @(posedge i_clk) begin
        t_result_beat got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.slot   = out_ch.slot_out;
            got.elem   = out_ch.element_out;
            got.last   = out_ch.last;
            got.status = out_ch.status;
            sb.check(got);
        end
    end

    // Receiver back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            out_stall = 0;
            out_ch.ready <= 1'b1;
        end else if (out_stall > 0) begin
            out_stall--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(1, 11) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_beat(logic mode, logic [15:0] elem, logic [9:0] qslot);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.element_in <= elem;
        in_ch.query_slot <= qslot;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_beat(mode, elem, qslot);
    endtask

    task automatic insert_vector(t_agent_vec v);
        for (int i = 0; i < sb.agents(); i++)
            send_beat(MODE_INSERT, v[i], 10'($urandom));
    endtask

    task automatic read_slot(logic [9:0] s);
        send_beat(MODE_READ, 16'($urandom), s);
    endtask

    // Wait for all expected results, then let the block go quiet
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [3:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.note_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly whole vectors, with repeats, reads and broken vectors mixed in
    task automatic random_phase(int n_items);
        int done, k;
        t_agent_vec v;
        done = 0;
        vec_pool.delete();
        while (done < n_items) begin
            k = $urandom_range(0, 99);
            if (k < 55 || (k < 70 && vec_pool.size() == 0)) begin
                for (int i = 0; i < VEC_AGENTS; i++) v[i] = pick_elem();
                vec_pool.push_back(v);
                insert_vector(v);
                done += sb.agents();
            end else if (k < 70) begin
                insert_vector(vec_pool[$urandom_range(0, vec_pool.size() - 1)]);
                done += sb.agents();
            end else if (k < 90) begin
                if (sb.n_entries > 0 && $urandom_range(0, 2) != 0)
                    read_slot(10'($urandom_range(0, sb.n_entries - 1)));
                else
                    read_slot(10'($urandom_range(0, NUM_SLOTS - 1)));
                done++;
            end else begin
                // partial vector cut short by a read
                k = $urandom_range(1, sb.agents() - 1);
                for (int i = 0; i < k; i++) send_beat(MODE_INSERT, pick_elem(), '0);
                read_slot(10'($urandom_range(0, NUM_SLOTS - 1)));
                done += k + 1;
            end
        end
        drain();
    endtask

    initial begin
        t_agent_vec v;
        sb = new();
        idle_on          = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_INSERT;
        in_ch.element_in = '0;
        in_ch.query_slot = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_AGENT_COUNT;
        cfg_ch.data      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: agent count above range acts as the maximum
        write_reg(REG_AGENT_COUNT, 4'd15);
        write_reg(REG_OWN_AGENT, 4'd3);
        for (int i = 0; i < VEC_AGENTS; i++) v[i] = 16'hFFFF;
        insert_vector(v);
        for (int i = 0; i < 3; i++) send_beat(MODE_INSERT, 16'h5555, '0);
        read_slot(10'd0);
        read_slot(10'd1023);
        for (int i = 0; i < VEC_AGENTS; i++) v[i] = (i % 2) ? 16'hAAAA : 16'h0000;
        insert_vector(v);
        read_slot(10'd1);
        drain();

        // Random phases; agent count only goes down once entries are stored
        idle_on = 1'b1;
        random_phase(25);
        write_reg(REG_AGENT_COUNT, 4'd8);
        write_reg(REG_OWN_AGENT, 4'd7);
        random_phase(25);
        write_reg(REG_AGENT_COUNT, 4'd5);
        write_reg(REG_OWN_AGENT, 4'd6);
        random_phase(25);
        write_reg(REG_AGENT_COUNT, 4'd3);
        write_reg(REG_OWN_AGENT, 4'd0);
        random_phase(25);
        write_reg(REG_AGENT_COUNT, 4'd2);
        write_reg(REG_OWN_AGENT, 4'd1);
        random_phase(15);

        // Last part runs without idling
        idle_on = 1'b0;
        write_reg(REG_AGENT_COUNT, 4'd0);
        write_reg(REG_OWN_AGENT, 4'd15);
        random_phase(15);

        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/vit_pkg.sv
rtl/vit_if.sv
rtl/vit_cell.sv
rtl/vector_interning_table.sv
verif/vector_interning_table_tb.sv
